/* rtl/mtrng_pkg.sv */
// mtrng_pkg: constants and types shared by the mt19937 word generator modules
// no dependencies

package mtrng_pkg;

	localparam int STATE_WORDS   = 624;
	localparam int MIDDLE_OFFSET = 397;
	localparam int WORD_W        = 32;
	localparam int IDX_W         = $clog2(STATE_WORDS + 1);

	localparam logic [WORD_W-1:0] SEED_MULT    = 32'd1812433253;
	localparam logic [WORD_W-1:0] TWIST_MATRIX = 32'h9908_B0DF;
	localparam logic [WORD_W-1:0] UPPER_BIT    = 32'h8000_0000;
	localparam logic [WORD_W-1:0] LOWER_BITS   = 32'h7FFF_FFFF;
	localparam logic [WORD_W-1:0] RESET_SEED   = 32'd19650218;

	typedef logic [WORD_W-1:0] word_t;

	// request to the seeder
	typedef struct packed {
		logic  start;
		word_t seed;
	} seed_ctl_t;

	// seeder output toward the cell row
	typedef struct packed {
		logic  push;
		logic  last;
		word_t word;
	} seed_stat_t;

endpackage

/* rtl/mtrng_cell.sv */
// mtrng_cell: one 32-bit word of the generator state, shifted from its neighbor
// depends on mtrng_pkg

module mtrng_cell (
	input  logic           clk,
	input  logic           shift_en,
	input  mtrng_pkg::word_t d,
	output mtrng_pkg::word_t q
);
	import mtrng_pkg::*;

	word_t word_q;

	always_ff @(posedge clk) begin
		if (shift_en) begin
			word_q <= d;
		end
	end

	assign q = word_q;

endmodule

/* rtl/mtrng_seeder.sv */
// mtrng_seeder: produces the 624 seed words, one per cycle, from the seed recurrence
// depends on mtrng_pkg; runs once out of reset with the reset seed, and again on each start

module mtrng_seeder (
	input  logic                   clk,
	input  logic                   arst_n,
	input  mtrng_pkg::seed_ctl_t   ctl,
	output mtrng_pkg::seed_stat_t  stat
);
	import mtrng_pkg::*;

	word_t            s_q;
	logic [IDX_W-1:0] idx_q;
	logic             active_q;
	word_t            mix;
	word_t            s_next;
	logic             last;

	assign mix    = s_q ^ (s_q >> 30);
	assign s_next = SEED_MULT * mix + {{(WORD_W-IDX_W){1'b0}}, idx_q};
	assign last   = active_q && (idx_q == IDX_W'(STATE_WORDS));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s_q      <= RESET_SEED;
			idx_q    <= IDX_W'(1);
			active_q <= 1'b1;
		end else if (ctl.start) begin
			s_q      <= ctl.seed;
			idx_q    <= IDX_W'(1);
			active_q <= 1'b1;
		end else if (active_q) begin
			s_q   <= s_next;
			idx_q <= idx_q + IDX_W'(1);
			if (last) begin
				active_q <= 1'b0;
			end
		end
	end

	assign stat.push = active_q;
	assign stat.last = last;
	assign stat.word = s_q;

endmodule

/* rtl/mt19937_random_word_generator.sv */
// Mersenne twister (MT19937) word generator: a row of 624 word cells forms a circular
// shift line; each draw twists the head word and pushes the result in at the tail.
// After reset the seeder fills the row from seed 19650218, during which no request
// is taken. A request without reseed returns one tempered word and the next one can
// follow in the following cycle, so draws stream at one word per cycle while the
// output is taken. A request with reseed refills the row from the configured seed,
// one word per cycle through the seeding multiplier, and returns its word once the
// refill is done. Seed writes are taken at any time and apply to the next reseed.
// depends on mtrng_pkg, mtrng_cell, mtrng_seeder

module mt19937_random_word_generator (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             cfg_valid,
	output logic             cfg_ready,
	input  mtrng_pkg::word_t seed_value,
	input  logic             in_valid,
	output logic             in_ready,
	input  logic             reseed,
	output logic             out_valid,
	input  logic             out_ready,
	output mtrng_pkg::word_t random_word
);
	import mtrng_pkg::*;

	localparam logic [1:0] ST_INIT = 2'd0;
	localparam logic [1:0] ST_IDLE = 2'd1;
	localparam logic [1:0] ST_FILL = 2'd2;
	localparam logic [1:0] ST_DRAW = 2'd3;

	logic [1:0] state_q;
	word_t      seed_q;
	logic       out_valid_q;
	word_t      word_q;

	seed_ctl_t  seed_ctl;
	seed_stat_t seed_stat;

	word_t cell_q [STATE_WORDS];
	word_t chain_in;
	logic  shift_en;
	logic  out_free;
	logic  in_beat;
	logic  draw_en;
	word_t x;
	word_t xa;
	word_t new_word;

	function automatic word_t temper(input word_t v);
		word_t y;
		y = v ^ (v >> 11);
		y = y ^ ((y << 7) & 32'h9D2C_5680);
		y = y ^ ((y << 15) & 32'hEFC6_0000);
		y = y ^ (y >> 18);
		return y;
	endfunction

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			seed_q <= RESET_SEED;
		end else if (cfg_valid) begin
			seed_q <= seed_value;
		end
	end

	assign out_free = !out_valid_q || out_ready;
	assign in_ready = (state_q == ST_IDLE) && out_free;
	assign in_beat  = in_valid && in_ready;
	assign draw_en  = (in_beat && !reseed) || ((state_q == ST_DRAW) && out_free);

	assign seed_ctl.start = in_beat && reseed;
	assign seed_ctl.seed  = seed_q;

	mtrng_seeder u_seeder (
		.clk   (clk),
		.arst_n(arst_n),
		.ctl   (seed_ctl),
		.stat  (seed_stat)
	);

	// head of the line is the current read position
	assign x        = (cell_q[0] & UPPER_BIT) | (cell_q[1] & LOWER_BITS);
	assign xa       = (x >> 1) ^ (x[0] ? TWIST_MATRIX : '0);
	assign new_word = cell_q[MIDDLE_OFFSET] ^ xa;

	assign shift_en = seed_stat.push || draw_en;
	assign chain_in = seed_stat.push ? seed_stat.word : new_word;

	for (genvar i = 0; i < STATE_WORDS; i++) begin : g_cell
		word_t d;
		if (i == STATE_WORDS - 1) begin : g_tail
			assign d = chain_in;
		end else begin : g_body
			assign d = cell_q[i+1];
		end
		mtrng_cell u_cell (
			.clk     (clk),
			.shift_en(shift_en),
			.d       (d),
			.q       (cell_q[i])
		);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_INIT;
		end else begin
			case (state_q)
				ST_INIT: begin
					if (seed_stat.last) begin
						state_q <= ST_IDLE;
					end
				end
				ST_IDLE: begin
					if (seed_ctl.start) begin
						state_q <= ST_FILL;
					end
				end
				ST_FILL: begin
					if (seed_stat.last) begin
						state_q <= ST_DRAW;
					end
				end
				ST_DRAW: begin
					if (out_free) begin
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (draw_en) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (draw_en) begin
			word_q <= temper(new_word);
		end
	end

	assign out_valid   = out_valid_q;
	assign random_word = word_q;

	// a seed push and a draw never share the shift line
	a_no_push_and_draw: assert property (@(posedge clk) disable iff (!arst_n)
		!(seed_stat.push && draw_en))
		else $error("seed push and draw in the same cycle");

	a_reseed_fills: assert property (@(posedge clk) disable iff (!arst_n)
		(in_beat && reseed) |=> (state_q == ST_FILL) && seed_stat.push)
		else $error("reseed beat did not start a fill");

	a_fill_ends: assert property (@(posedge clk) disable iff (!arst_n)
		seed_stat.last |=> !seed_stat.push && (state_q == ST_IDLE || state_q == ST_DRAW))
		else $error("fill did not end cleanly");

	a_draw_shows: assert property (@(posedge clk) disable iff (!arst_n)
		draw_en |=> out_valid_q)
		else $error("draw lost its output beat");

	a_busy_while_push: assert property (@(posedge clk) disable iff (!arst_n)
		seed_stat.push |-> !in_ready)
		else $error("request taken while the table is filling");

endmodule

/* dv/mt19937_random_word_generator_checker.sv */
// mt19937_random_word_generator_checker: watches the seed, request and word channels,
// predicts each tempered word and compares it with the block's output
// depends on mtrng_pkg

module mt19937_random_word_generator_checker (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             cfg_valid,
	input  logic             cfg_ready,
	input  mtrng_pkg::word_t seed_value,
	input  logic             in_valid,
	input  logic             in_ready,
	input  logic             reseed,
	input  logic             out_valid,
	input  logic             out_ready,
	input  mtrng_pkg::word_t random_word,
	output int               mismatches,
	output int               pending
);

	timeunit 1ns;
	timeprecision 1ps;

	import mtrng_pkg::*;

	word_t       mt_table [STATE_WORDS];
	int unsigned mt_pos;
	word_t       mt_seed;
	word_t       expected_words [$];

	function automatic void fill_from_seed(input word_t s);
		word_t w;
		w = s;
		mt_table[0] = w;
		for (int i = 1; i < STATE_WORDS; i++) begin
			w = SEED_MULT * (w ^ (w >> 30)) + word_t'(i);
			mt_table[i] = w;
		end
		mt_pos = 0;
	endfunction

	function automatic word_t temper_word(input word_t x);
		word_t y;
		y = x ^ (x >> 11);
		y = y ^ ((y << 7) & 32'h9D2C_5680);
		y = y ^ ((y << 15) & 32'hEFC6_0000);
		y = y ^ (y >> 18);
		return y;
	endfunction

	// refill if asked, twist the read-position entry in place and return it tempered
	function automatic word_t twist_next(input logic refill);
		int unsigned k, nxt, mid;
		word_t       x, xa;
		if (refill) begin
			fill_from_seed(mt_seed);
		end
		k   = (mt_pos >= STATE_WORDS) ? 0 : mt_pos;
		nxt = (k == STATE_WORDS - 1) ? 0 : k + 1;
		mid = k + MIDDLE_OFFSET;
		if (mid >= STATE_WORDS) begin
			mid = mid - STATE_WORDS;
		end
		x  = (mt_table[k] & UPPER_BIT) | (mt_table[nxt] & LOWER_BITS);
		xa = x >> 1;
		if (x[0]) begin
			xa = xa ^ TWIST_MATRIX;
		end
		x = mt_table[mid] ^ xa;
		mt_table[k] = x;
		mt_pos = nxt;
		return temper_word(x);
	endfunction

	task automatic report_mismatch(input string msg);
		$display("[%0t] MISMATCH: %s", $realtime, msg);
		mismatches++;
	endtask

	initial begin
		mismatches = 0;
		pending    = 0;
	end

	always @(posedge clk or negedge arst_n) begin
		word_t want;
		if (!arst_n) begin
			mt_seed = RESET_SEED;
			fill_from_seed(mt_seed);
			expected_words.delete();
		end else begin
			if (cfg_valid && cfg_ready) begin
				mt_seed = seed_value;
			end
			// request beat first so a same-edge output beat finds its word
			if (in_valid && in_ready) begin
				expected_words.push_back(twist_next(reseed));
			end
			if (out_valid && out_ready) begin
				if (expected_words.size() == 0) begin
					report_mismatch($sformatf("word beat 0x%08h with no request outstanding",
						random_word));
				end else begin
					want = expected_words.pop_front();
					if (random_word !== want) begin
						report_mismatch($sformatf("random_word 0x%08h, predicted 0x%08h",
							random_word, want));
					end
				end
			end
		end
		pending = expected_words.size();
	end

endmodule

/* dv/mt19937_random_word_generator_tb.sv */
// mt19937_random_word_generator_tb: drives seed writes and draw requests with random
// gaps and output stalls, and gives the verdict from the checker's mismatch and pending counts
// depends on mtrng_pkg, mt19937_random_word_generator, mt19937_random_word_generator_checker

module mt19937_random_word_generator_tb;

	timeunit 1ns;
	timeprecision 1ps;

	import mtrng_pkg::*;

	localparam int RANDOM_DRAWS   = 1900;
	localparam int WATCHDOG_LIMIT = 6000;
	localparam int DRAIN_CYCLES   = 16;

	logic  clk;
	logic  arst_n;
	logic  cfg_valid;
	logic  cfg_ready;
	word_t seed_value;
	logic  in_valid;
	logic  in_ready;
	logic  reseed;
	logic  out_valid;
	logic  out_ready;
	word_t random_word;

	int mismatches;
	int pending;
	int quiet_cycles;
	bit in_gaps;
	bit out_stalls;

	mt19937_random_word_generator u_dut (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg_valid  (cfg_valid),
		.cfg_ready  (cfg_ready),
		.seed_value (seed_value),
		.in_valid   (in_valid),
		.in_ready   (in_ready),
		.reseed     (reseed),
		.out_valid  (out_valid),
		.out_ready  (out_ready),
		.random_word(random_word)
	);

	mt19937_random_word_generator_checker u_checker (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg_valid  (cfg_valid),
		.cfg_ready  (cfg_ready),
		.seed_value (seed_value),
		.in_valid   (in_valid),
		.in_ready   (in_ready),
		.reseed     (reseed),
		.out_valid  (out_valid),
		.out_ready  (out_ready),
		.random_word(random_word),
		.mismatches (mismatches),
		.pending    (pending)
	);

	initial begin
		clk = 1'b0;
	end

	always #6 clk = ~clk;

	// called right after a beat or at a negedge; leaves valid high until the next call
	task automatic send_draw(input logic refill);
		int gap;
		gap = in_gaps ? $urandom_range(0, 7) : 0;
		@(negedge clk);
		if (gap != 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		in_valid <= 1'b1;
		reseed   <= refill;
		do @(posedge clk); while (!in_ready);
	endtask

	// drop the request line and wait for every predicted word to come back
	task automatic wait_idle();
		@(negedge clk);
		in_valid <= 1'b0;
		while (pending != 0) @(negedge clk);
	endtask

	task automatic write_seed(input word_t value);
		@(negedge clk);
		cfg_valid  <= 1'b1;
		seed_value <= value;
		do @(posedge clk); while (!cfg_ready);
		@(negedge clk);
		cfg_valid <= 1'b0;
	endtask

	function automatic word_t pick_seed();
		case ($urandom_range(0, 5))
			0:       return '0;
			1:       return '1;
			2:       return 32'd1;
			default: return word_t'($urandom());
		endcase
	endfunction

	// output side: per word, a random stall before ready goes high while stalls are on
	initial begin
		int stall;
		out_ready = 1'b0;
		wait (arst_n);
		forever begin
			@(negedge clk);
			stall = out_stalls ? $urandom_range(0, 7) : 0;
			if (stall != 0) begin
				out_ready <= 1'b0;
				repeat (stall) @(negedge clk);
			end
			out_ready <= 1'b1;
			do @(posedge clk); while (!out_valid);
		end
	end

	// seeding after reset and every reseed leave all channels quiet while the row fills
	always @(posedge clk) begin
		if (!arst_n || (in_valid && in_ready) || (out_valid && out_ready) ||
			(cfg_valid && cfg_ready)) begin
			quiet_cycles <= 0;
		end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
			$display("[%0t] watchdog: no beat for %0d cycles", $realtime, quiet_cycles);
			$display("Testbench completed WITH ERRORS");
			$finish;
		end else begin
			quiet_cycles <= quiet_cycles + 1;
		end
	end

	initial begin
		int  sent;
		int  run_len;
		bit  long_run;
		arst_n       = 1'b0;
		cfg_valid    = 1'b0;
		seed_value   = '0;
		in_valid     = 1'b0;
		reseed       = 1'b0;
		in_gaps      = 1'b0;
		out_stalls   = 1'b0;
		quiet_cycles = 0;
		repeat (5) @(negedge clk);
		arst_n = 1'b1;

		// directed: draws from the reset table, reseed before any seed write
		for (int i = 0; i < 3; i++) send_draw(1'b0);
		send_draw(1'b1);
		wait_idle();

		in_gaps    = 1'b1;
		out_stalls = 1'b1;
		write_seed('0);
		send_draw(1'b1);
		send_draw(1'b0);
		send_draw(1'b0);
		wait_idle();

		// all-ones seed, then two reseeds back to back
		write_seed('1);
		send_draw(1'b1);
		send_draw(1'b0);
		send_draw(1'b1);
		send_draw(1'b1);
		wait_idle();

		in_gaps    = 1'b0;
		out_stalls = 1'b0;
		write_seed(32'd5489);
		send_draw(1'b1);
		for (int i = 0; i < 3; i++) send_draw(1'b0);
		wait_idle();

		write_seed(UPPER_BIT);
		send_draw(1'b1);
		send_draw(1'b0);
		wait_idle();

		// random phases: new seed, usually a reseed, then a stream of draws with rare reseeds;
		// the first phase, free of these, runs past the table length so the position wraps
		sent     = 0;
		long_run = 1'b1;
		while (sent < RANDOM_DRAWS) begin
			wait_idle();
			write_seed(pick_seed());
			in_gaps    = ($urandom_range(0, 2) != 0);
			out_stalls = ($urandom_range(0, 2) != 0);
			run_len    = long_run ? STATE_WORDS + 120 : $urandom_range(40, 240);
			for (int i = 0; i < run_len; i++) begin
				if (i == 0) begin
					send_draw($urandom_range(0, 3) != 0);
				end else begin
					send_draw(!long_run && $urandom_range(0, 99) == 0);
				end
				sent++;
			end
			long_run = 1'b0;
		end

		wait_idle();
		repeat (DRAIN_CYCLES) @(negedge clk);
		if (mismatches == 0 && pending == 0) begin
			$display("Testbench completed without errors");
		end else begin
			$display("Testbench completed WITH ERRORS");
		end
		$finish;
	end

endmodule
